### design/pth_pkg.sv
// ----------------------------------------------------------------------------
// pth_pkg
// Shared payload types, register indexes and pipeline latencies.
// ----------------------------------------------------------------------------
package pth_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } pth_in_t;

    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_invalid;
    } pth_out_t;

    localparam logic [2:0] CFG_TEMP_CALIB       = 3'd0;
    localparam logic [2:0] CFG_PRESS_CALIB_LOW  = 3'd1;
    localparam logic [2:0] CFG_PRESS_CALIB_HIGH = 3'd2;
    localparam logic [2:0] CFG_PRESS_CALIB_LAST = 3'd3;
    localparam logic [2:0] CFG_HUM_CALIB_LOW    = 3'd4;
    localparam logic [2:0] CFG_HUM_CALIB_HIGH   = 3'd5;

    localparam int DIV_W     = 64;
    localparam int TEMP_LAT  = 4;
    localparam int PRESS_LAT = 9 + DIV_W + 7;
    localparam int HUM_LAT   = 12;
    localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

endpackage

### design/pth_delay.sv
// ----------------------------------------------------------------------------
// pth_delay
// Enabled shift line that keeps side data aligned with the compute stages.
// ----------------------------------------------------------------------------
module pth_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[N-1];
endmodule

### design/pth_temp.sv
// ----------------------------------------------------------------------------
// pth_temp
// Four-stage fine temperature pipeline with the centi-degree result.
// ----------------------------------------------------------------------------
module pth_temp (
    input  logic        clk,
    input  logic        en,
    input  logic [19:0] raw_t,
    input  logic [47:0] calib,
    output logic [31:0] tfine,
    output logic [23:0] tcent
);
    logic [31:0] t2, t3;
    logic [31:0] a_reg, dt_reg, m1_reg, m2_reg, x1_reg, m3_reg, tfine_reg;
    logic [31:0] tc_sum;

    assign t2 = {{16{calib[31]}}, calib[31:16]};
    assign t3 = {{16{calib[47]}}, calib[47:32]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= {15'd0, raw_t[19:3]} - {15'd0, calib[15:0], 1'b0};
            dt_reg    <= {16'd0, raw_t[19:4]} - {16'd0, calib[15:0]};
            m1_reg    <= a_reg * t2;
            m2_reg    <= dt_reg * dt_reg;
            x1_reg    <= 32'($signed(m1_reg) >>> 11);
            m3_reg    <= 32'($signed(m2_reg) >>> 12) * t3;
            tfine_reg <= x1_reg + 32'($signed(m3_reg) >>> 14);
        end
    end

    // times five plus rounding; the arithmetic shift by eight is the top bits
    assign tc_sum = {tfine_reg[29:0], 2'b00} + tfine_reg + 32'd128;
    assign tfine  = tfine_reg;
    assign tcent  = tc_sum[31:8];
endmodule

### design/pth_press.sv
// ----------------------------------------------------------------------------
// pth_press
// 64-bit pressure pipeline with a one-bit-per-stage signed divider.
// ----------------------------------------------------------------------------
module pth_press (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] tfine,
    input  logic [19:0] raw_p,
    input  logic [63:0] calib_low,
    input  logic [63:0] calib_high,
    input  logic [15:0] calib_last,
    output logic [31:0] press,
    output logic        invalid
);
    import pth_pkg::*;

    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic        [15:0] p1;

    logic signed [32:0] v1_reg;
    logic        [19:0] adcp_reg [6];
    logic signed [65:0] sq_full;
    logic signed [48:0] m5_full, m2_full;
    logic        [63:0] sq_reg, m5_reg, m2_reg, m5b_reg, m2b_reg;
    logic signed [79:0] a6_full, a3_full;
    logic        [63:0] a6_reg, a3_reg;
    logic        [63:0] v2_reg, w_reg, w47_reg, prod_reg;
    logic        [63:0] v2b_reg, v2c_reg, den_reg, num0_reg, num_reg, den2_reg;
    logic        [20:0] q0;
    logic        [63:0] rem_reg [DIV_W+1];
    logic        [63:0] dq_reg  [DIV_W+1];
    logic        [63:0] dv_reg  [DIV_W+1];
    logic               neg_reg [DIV_W+1];
    logic               inv_reg [DIV_W+1];
    logic               inv8_reg;
    logic        [63:0] q_reg, q11_reg, q12_reg, q13_reg, q13s;
    logic        [63:0] ll_reg, s_reg, t9_reg, m8_reg, m8b_reg, m8c_reg;
    logic        [31:0] lh_reg;
    logic signed [79:0] m8_full, t9_full;
    logic        [63:0] sum_reg, f_reg;
    logic               inv_p_reg [6];
    logic        [31:0] press_reg;
    logic               invalid_reg;

    assign p1 = calib_low[15:0];
    assign p2 = calib_low[31:16];
    assign p3 = calib_low[47:32];
    assign p4 = calib_low[63:48];
    assign p5 = calib_high[15:0];
    assign p6 = calib_high[31:16];
    assign p7 = calib_high[47:32];
    assign p8 = calib_high[63:48];
    assign p9 = calib_last;

    assign sq_full = v1_reg * v1_reg;
    assign m5_full = v1_reg * p5;
    assign m2_full = v1_reg * p2;
    assign a6_full = $signed(sq_reg) * p6;
    assign a3_full = $signed(sq_reg) * p3;
    assign q0      = 21'd1048576 - {1'b0, adcp_reg[5]};

    // front end: offsets, products and the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg      <= $signed({tfine[31], tfine}) - 33'sd128000;
            adcp_reg[0] <= raw_p;
            for (int i = 1; i < 6; i++)
            begin
                adcp_reg[i] <= adcp_reg[i-1];
            end
            sq_reg   <= sq_full[63:0];
            m5_reg   <= {{15{m5_full[48]}}, m5_full};
            m2_reg   <= {{15{m2_full[48]}}, m2_full};
            a6_reg   <= a6_full[63:0];
            a3_reg   <= a3_full[63:0];
            m5b_reg  <= m5_reg;
            m2b_reg  <= m2_reg;
            v2_reg   <= a6_reg + (m5b_reg << 17) + ({{48{p4[15]}}, p4} << 35);
            w_reg    <= 64'($signed(a3_reg) >>> 8) + (m2b_reg << 12);
            w47_reg  <= w_reg + (64'd1 << 47);
            v2b_reg  <= v2_reg;
            prod_reg <= w47_reg * {48'd0, p1};
            v2c_reg  <= v2b_reg;
            den_reg  <= 64'($signed(prod_reg) >>> 33);
            num0_reg <= ({43'd0, q0} << 31) - v2c_reg;
            num_reg  <= num0_reg * 64'd3125;
            den2_reg <= den_reg;
            inv8_reg <= (den_reg == 64'd0);
            // take magnitudes; the most negative value maps to 2^63 unsigned
            rem_reg[0] <= '0;
            dq_reg[0]  <= num_reg[63]  ? (~num_reg + 64'd1)  : num_reg;
            dv_reg[0]  <= den2_reg[63] ? (~den2_reg + 64'd1) : den2_reg;
            neg_reg[0] <= num_reg[63] ^ den2_reg[63];
            inv_reg[0] <= inv8_reg;
        end
    end

    // restoring divider: one quotient bit per stage
    for (genvar k = 1; k <= DIV_W; k++)
    begin : g_div
        logic [64:0] shifted;
        logic        fits;
        logic [64:0] diff;

        assign shifted = {rem_reg[k-1], dq_reg[k-1][63]};
        assign diff    = shifted - {1'b0, dv_reg[k-1]};
        assign fits    = !diff[64];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? diff[63:0] : shifted[63:0];
                dq_reg[k]  <= {dq_reg[k-1][62:0], fits};
                dv_reg[k]  <= dv_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                inv_reg[k] <= inv_reg[k-1];
            end
        end
    end

    assign q13s    = 64'($signed(q_reg) >>> 13);
    assign m8_full = $signed(q_reg) * p8;
    assign t9_full = $signed(s_reg) * p9;

    // back end: square of the scaled quotient, corrections and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg        <= neg_reg[DIV_W] ? (~dq_reg[DIV_W] + 64'd1) : dq_reg[DIV_W];
            inv_p_reg[0] <= inv_reg[DIV_W];
            for (int i = 1; i < 6; i++)
            begin
                inv_p_reg[i] <= inv_p_reg[i-1];
            end
            ll_reg  <= {32'd0, q13s[31:0]} * {32'd0, q13s[31:0]};
            lh_reg  <= q13s[31:0] * q13s[63:32];
            m8_reg  <= m8_full[63:0];
            q11_reg <= q_reg;
            s_reg   <= ll_reg + {lh_reg[30:0], 33'd0};
            m8b_reg <= m8_reg;
            q12_reg <= q11_reg;
            t9_reg  <= t9_full[63:0];
            m8c_reg <= m8b_reg;
            q13_reg <= q12_reg;
            sum_reg <= q13_reg + 64'($signed(t9_reg) >>> 25)
                       + 64'($signed(m8c_reg) >>> 19);
            f_reg   <= 64'($signed(sum_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);
            if (inv_p_reg[5] || f_reg[63])
            begin
                press_reg <= '0;
            end
            else if (|f_reg[62:32])
            begin
                press_reg <= '1;
            end
            else
            begin
                press_reg <= f_reg[31:0];
            end
            invalid_reg <= inv_p_reg[5];
        end
    end

    assign press   = press_reg;
    assign invalid = invalid_reg;
endmodule

### design/pth_hum.sv
// ----------------------------------------------------------------------------
// pth_hum
// Twelve-stage 32-bit humidity pipeline with the 0 to 100 percent clamp.
// ----------------------------------------------------------------------------
module pth_hum (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] tfine,
    input  logic [15:0] raw_h,
    input  logic [39:0] calib_low,
    input  logic [31:0] calib_high,
    output logic [16:0] hum
);
    import pth_pkg::*;

    logic [31:0] h1, h2, h3, h6, h4, h5;
    logic [31:0] v_reg, hv5_reg, m6_reg, m3_reg;
    logic [15:0] adch_reg [2];
    logic [31:0] ha_reg [5];
    logic [31:0] b1_reg, b2_reg, hb0_reg, hb1_reg, hb2_reg, hb_reg;
    logic [31:0] vv_reg [3];
    logic [31:0] hs, sqh_reg, t_reg, diff_reg;
    logic [16:0] hum_reg;

    assign h1 = {24'd0, calib_low[7:0]};
    assign h2 = {{16{calib_low[23]}}, calib_low[23:8]};
    assign h3 = {24'd0, calib_low[31:24]};
    assign h6 = {{24{calib_low[39]}}, calib_low[39:32]};
    assign h4 = {{16{calib_high[15]}}, calib_high[15:0]};
    assign h5 = {{16{calib_high[31]}}, calib_high[31:16]};
    assign hs = 32'($signed(vv_reg[0]) >>> 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg       <= tfine - 32'd76800;
            adch_reg[0] <= raw_h;
            hv5_reg     <= h5 * v_reg;
            m6_reg      <= v_reg * h6;
            m3_reg      <= v_reg * h3;
            adch_reg[1] <= adch_reg[0];
            ha_reg[0]   <= 32'($signed({2'd0, adch_reg[1], 14'd0} - {h4[11:0], 20'd0}
                           - hv5_reg + 32'd16384) >>> 15);
            b1_reg      <= 32'($signed(m6_reg) >>> 10);
            b2_reg      <= 32'($signed(m3_reg) >>> 11) + 32'd32768;
            for (int i = 1; i < 5; i++)
            begin
                ha_reg[i] <= ha_reg[i-1];
            end
            hb0_reg   <= b1_reg * b2_reg;
            hb1_reg   <= 32'($signed(hb0_reg) >>> 10) + 32'd2097152;
            hb2_reg   <= hb1_reg * h2;
            hb_reg    <= 32'($signed(hb2_reg + 32'd8192) >>> 14);
            vv_reg[0] <= ha_reg[4] * hb_reg;
            vv_reg[1] <= vv_reg[0];
            vv_reg[2] <= vv_reg[1];
            sqh_reg   <= hs * hs;
            t_reg     <= 32'($signed(sqh_reg) >>> 7) * h1;
            diff_reg  <= vv_reg[2] - 32'($signed(t_reg) >>> 4);
            if (diff_reg[31])
            begin
                hum_reg <= '0;
            end
            else if (diff_reg > HUM_MAX)
            begin
                hum_reg <= HUM_MAX[28:12];
            end
            else
            begin
                hum_reg <= diff_reg[28:12];
            end
        end
    end

    assign hum = hum_reg;
endmodule

### design/pth_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation_top
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// One sample triple is taken per clock unless the pipeline holds, and each
// yields one result: four stages form the fine temperature, then the pressure
// path runs 80 stages, of which 64 are the one-bit-per-stage signed divider;
// the shorter temperature and humidity results wait in delay lines to line up
// with it. The whole pipeline advances together; it holds only while a result
// sits in the output stage and out_ready is low. Calibration is written through
// the plain write port and must not change while samples are in flight.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pth_pkg::pth_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pth_pkg::pth_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import pth_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_calib_low_reg, press_calib_high_reg;
    logic [15:0] press_calib_last_reg;
    logic [39:0] hum_calib_low_reg;
    logic [31:0] hum_calib_high_reg;

    logic [TOTAL_LAT-1:0] valid_reg;
    logic                 en;
    logic [31:0]          tfine;
    logic [23:0]          tcent, tcent_d;
    logic [35:0]          raw_ph_d;
    logic [31:0]          press;
    logic                 press_inv;
    logic [16:0]          hum, hum_d;

    // advance everything unless the output stage holds an untaken result
    assign en       = !valid_reg[TOTAL_LAT-1] || out_ready;
    assign in_ready = en;

    // calibration registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg       <= '0;
            press_calib_low_reg  <= '0;
            press_calib_high_reg <= '0;
            press_calib_last_reg <= '0;
            hum_calib_low_reg    <= '0;
            hum_calib_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP_CALIB:       temp_calib_reg       <= cfg_data[47:0];
                CFG_PRESS_CALIB_LOW:  press_calib_low_reg  <= cfg_data;
                CFG_PRESS_CALIB_HIGH: press_calib_high_reg <= cfg_data;
                CFG_PRESS_CALIB_LAST: press_calib_last_reg <= cfg_data[15:0];
                CFG_HUM_CALIB_LOW:    hum_calib_low_reg    <= cfg_data[39:0];
                CFG_HUM_CALIB_HIGH:   hum_calib_high_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // valid bits march alongside the data; a transfer in sets the first one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], in_valid};
        end
    end

    pth_temp u_temp (
        .clk   (clk),
        .en    (en),
        .raw_t (in_data.raw_temperature),
        .calib (temp_calib_reg),
        .tfine (tfine),
        .tcent (tcent)
    );

    // hold the raw pressure and humidity while the fine temperature forms
    pth_delay #(.W(36), .N(TEMP_LAT)) u_raw_dly (
        .clk (clk),
        .en  (en),
        .d   ({in_data.raw_pressure, in_data.raw_humidity}),
        .q   (raw_ph_d)
    );

    pth_press u_press (
        .clk        (clk),
        .en         (en),
        .tfine      (tfine),
        .raw_p      (raw_ph_d[35:16]),
        .calib_low  (press_calib_low_reg),
        .calib_high (press_calib_high_reg),
        .calib_last (press_calib_last_reg),
        .press      (press),
        .invalid    (press_inv)
    );

    pth_hum u_hum (
        .clk        (clk),
        .en         (en),
        .tfine      (tfine),
        .raw_h      (raw_ph_d[15:0]),
        .calib_low  (hum_calib_low_reg),
        .calib_high (hum_calib_high_reg),
        .hum        (hum)
    );

    // align temperature and humidity with the pressure result
    pth_delay #(.W(24), .N(PRESS_LAT)) u_tcent_dly (
        .clk (clk),
        .en  (en),
        .d   (tcent),
        .q   (tcent_d)
    );

    pth_delay #(.W(17), .N(PRESS_LAT - HUM_LAT)) u_hum_dly (
        .clk (clk),
        .en  (en),
        .d   (hum),
        .q   (hum_d)
    );

    assign out_valid                  = valid_reg[TOTAL_LAT-1];
    assign out_data.temperature_centi = tcent_d;
    assign out_data.pressure_q24_8    = press;
    assign out_data.humidity_q22_10   = hum_d;
    assign out_data.pressure_invalid  = press_inv;

    // a zero divisor must force the pressure field to zero
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pressure_invalid |-> out_data.pressure_q24_8 == 32'd0)
        else $error("pressure not forced to zero on invalid divisor");

    // the clamp keeps humidity within 100 percent
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    // a held pipeline neither loses nor creates items
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("valid bits moved during a hold");

    // no transfer in while the output stage is blocked
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output blocked");
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor compensation pipeline: calibration sets
// are loaded while idle, raw sample triples are pushed through the
// valid/ready channel and each result is compared with a model of the
// integer compensation arithmetic.
// ----------------------------------------------------------------------------
module tb;
    import pth_pkg::*;

    localparam int MAX_CYCLES = 600000;

    // Expected results are queued in order and matched against each output
    // transfer as it happens.
    class comp_scoreboard;
        pth_out_t pending[$];
        int       mismatches;
        int       checked;

        function void note_sample(pth_out_t r);
            pending.push_back(r);
        endfunction

        function void check_result(pth_out_t got);
            pth_out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp t=%0d p=%h h=%0d inv=%b got t=%0d p=%h h=%0d inv=%b",
                             checked, want.temperature_centi, want.pressure_q24_8,
                             want.humidity_q22_10, want.pressure_invalid,
                             got.temperature_centi, got.pressure_q24_8,
                             got.humidity_q22_10, got.pressure_invalid);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pth_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    pth_out_t    out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    comp_scoreboard sb;
    int  cycle_count;
    bit  hold_off_req;
    bit  drain_mode;
    int  sent_count;

    // Local copies of the calibration registers
    logic [47:0] cal_t;
    logic [63:0] cal_pl;
    logic [63:0] cal_ph;
    logic [15:0] cal_p9;
    logic [39:0] cal_hl;
    logic [31:0] cal_hh;

    pth_sensor_compensation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Compute the compensated result for one sample with the current
    // calibration; 32-bit paths wrap as int, pressure wraps as longint.
    function automatic pth_out_t compensate(pth_in_t s);
        pth_out_t r;
        int t1, t2, t3, x1, x2, dt, tfine, tc;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, q13;
        int h1, h2, h3, h4, h5, h6, v, ha, hb, hs;
        t1 = int'(cal_t[15:0]);
        t2 = int'($signed(cal_t[31:16]));
        t3 = int'($signed(cal_t[47:32]));
        x1 = (((int'(s.raw_temperature) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        dt = (int'(s.raw_temperature) >>> 4) - t1;
        x2 = (((dt * dt) >>> 12) * t3) >>> 14;
        tfine = x1 + x2;
        tc = (tfine * 5 + 128) >>> 8;
        r.temperature_centi = tc[23:0];

        p1 = longint'(cal_pl[15:0]);
        p2 = longint'($signed(cal_pl[31:16]));
        p3 = longint'($signed(cal_pl[47:32]));
        p4 = longint'($signed(cal_pl[63:48]));
        p5 = longint'($signed(cal_ph[15:0]));
        p6 = longint'($signed(cal_ph[31:16]));
        p7 = longint'($signed(cal_ph[47:32]));
        p8 = longint'($signed(cal_ph[63:48]));
        p9 = longint'($signed(cal_p9));
        v1 = longint'(tfine) - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.pressure_invalid = 1'b0;
        r.pressure_q24_8   = '0;
        if (v1 == 0)
            r.pressure_invalid = 1'b1;
        else
        begin
            q = 1048576 - longint'(s.raw_pressure);
            q = ((q <<< 31) - v2) * 3125;
            // the most negative value over minus one wraps to itself
            if (q == 64'sh8000000000000000 && v1 == -1)
                q = q;
            else
                q = q / v1;
            q13 = q >>> 13;
            v1 = (p9 * q13 * q13) >>> 25;
            v2 = (p8 * q) >>> 19;
            q = ((q + v1 + v2) >>> 8) + (p7 <<< 4);
            if (q < 0)
                r.pressure_q24_8 = '0;
            else if (q > 64'sh00000000FFFFFFFF)
                r.pressure_q24_8 = '1;
            else
                r.pressure_q24_8 = q[31:0];
        end

        h1 = int'(cal_hl[7:0]);
        h2 = int'($signed(cal_hl[23:8]));
        h3 = int'(cal_hl[31:24]);
        h6 = int'($signed(cal_hl[39:32]));
        h4 = int'($signed(cal_hh[15:0]));
        h5 = int'($signed(cal_hh[31:16]));
        v  = tfine - 76800;
        ha = ((int'(s.raw_humidity) <<< 14) - (h4 <<< 20) - (h5 * v) + 16384) >>> 15;
        hb = ((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768);
        hb = (hb >>> 10) + 2097152;
        hb = (hb * h2 + 8192) >>> 14;
        v  = ha * hb;
        hs = v >>> 15;
        v  = v - ((((hs * hs) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        else if (v > int'(HUM_MAX))
            v = int'(HUM_MAX);
        r.humidity_q22_10 = v[28:12];
        return r;
    endfunction

    // Write one calibration register and mirror it locally.
    task automatic write_calib(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TEMP_CALIB:       cal_t  = val[47:0];
            CFG_PRESS_CALIB_LOW:  cal_pl = val;
            CFG_PRESS_CALIB_HIGH: cal_ph = val;
            CFG_PRESS_CALIB_LAST: cal_p9 = val[15:0];
            CFG_HUM_CALIB_LOW:    cal_hl = val[39:0];
            CFG_HUM_CALIB_HIGH:   cal_hh = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_calib(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9, logic [39:0] hl, logic [31:0] hh);
        write_calib(CFG_TEMP_CALIB, {16'h0, t});
        write_calib(CFG_PRESS_CALIB_LOW, pl);
        write_calib(CFG_PRESS_CALIB_HIGH, ph);
        write_calib(CFG_PRESS_CALIB_LAST, {48'h0, p9});
        write_calib(CFG_HUM_CALIB_LOW, {24'h0, hl});
        write_calib(CFG_HUM_CALIB_HIGH, {32'h0, hh});
    endtask

    // Offer one sample and hold it until the transfer; called at a falling edge.
    task automatic send_sample(pth_in_t s);
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(compensate(s));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait for every expected result, then let the pipe settle.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (TOTAL_LAT + 8) @(negedge clk);
    endtask

    function automatic pth_in_t rand_sample();
        pth_in_t s;
        s.raw_temperature = 20'($urandom);
        s.raw_pressure    = 20'($urandom);
        s.raw_humidity    = 16'($urandom);
        return s;
    endfunction

    // Typical factory calibration with a touch of random spread.
    task automatic load_typical();
        load_calib({16'hFC18, 16'd26435 + 16'($urandom_range(0, 200)), 16'd27504},
                   {16'd7172, 16'd8995, 16'hD4BD, 16'd36477},
                   {16'hD3E8 + 16'($urandom_range(0, 40)), 16'h003C, 16'hFFF9,
                    16'd140},
                   16'd4285,
                   {8'd30, 8'd0, 16'd364, 8'd75},
                   {16'd50, 16'd299});
    endtask

    task automatic random_burst(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            int blen;
            blen = $urandom_range(1, 30);
            repeat (blen)
            begin
                if (n < count)
                begin
                    send_sample(rand_sample());
                    n++;
                end
            end
            // some bursts run back to back with no gap
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 8));
        end
    endtask

    // Receiver: random stall pattern, long hold-offs on request.
    initial
    begin
        int hold_cnt;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 300; hold_cnt++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (drain_mode)
                out_ready <= 1'b1;
            else
            begin
                case (cycle_count % 97 < 40 ? 0 : $urandom_range(1, 3))
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 4) == 0);
                    default: out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Check each output transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Cycle counter and time-out.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pth_in_t s;
        int k;
        sb = new();
        cycle_count  = 0;
        hold_off_req = 1'b0;
        drain_mode   = 1'b0;
        sent_count   = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; cal_hl = '0; cal_hh = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset calibration: pressure divisor is zero, so flag the invalid case.
        send_sample('0);
        send_sample('1);
        drain_pipe();

        // Directed: typical calibration with field extremes.
        load_typical();
        send_sample('0);
        send_sample('1);
        s = '0; s.raw_temperature = '1; send_sample(s);
        s = '0; s.raw_pressure = '1;    send_sample(s);
        s = '0; s.raw_humidity = '1;    send_sample(s);
        s = '{20'd519888, 20'd415148, 16'd30000}; send_sample(s);
        s = '{20'd519888, 20'd0, 16'd0};          send_sample(s);
        s = '{20'd400000, 20'd1048575, 16'd65535}; send_sample(s);
        drain_pipe();

        // Directed: all-ones then mixed-extreme calibration.
        load_calib('1, '1, '1, '1, '1, '1);
        send_sample('0);
        send_sample('1);
        send_sample('{20'h80000, 20'h80000, 16'h8000});
        drain_pipe();
        load_calib({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000,
                   {8'h80, 8'hFF, 16'h8000, 8'hFF}, {16'h7FFF, 16'h8000});
        send_sample('0);
        send_sample('1);
        send_sample('{20'h12345, 20'hABCDE, 16'h5A5A});
        drain_pipe();

        // Random part: several calibration phases, typical and fully random.
        for (k = 0; k < 6; k++)
        begin
            if (k % 2 == 0)
                load_typical();
            else
                load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           16'($urandom), {$urandom, $urandom}, $urandom);
            if (k == 2)
            begin
                // long receiver hold-off while samples keep coming
                hold_off_req = 1'b1;
                random_burst(150);
            end
            else
                random_burst(195);
            // pause until every result has arrived
            drain_pipe();
        end

        drain_mode = 1'b1;
        drain_pipe();
        $display("Summary: %0d samples over ten calibration settings, %0d results checked",
                 sent_count, sb.checked);
        $display("Summary: reset, extreme, typical and random calibration with stalls covered");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
